/* hdl/sitda_pkg.sv */
// Shared types, constants and conversion helpers for the integer to decimal text unit.
package sitda_pkg;

	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned NUM_DIGITS     = 10;
	localparam int unsigned BCD_W          = 4 * NUM_DIGITS;
	localparam int unsigned BITS_PER_STAGE = 8;
	localparam int unsigned DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Payload of one value while it moves down the conversion pipeline.
	typedef struct packed {
		logic                 neg;
		logic [VALUE_W-1:0]   mag;
		logic [BCD_W-1:0]     bcd;
	} stage_t;

	// Eight shift-and-add-3 steps: folds the given bits, MSB first, into the BCD word.
	function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] bcd_in,
			input logic [BITS_PER_STAGE-1:0] bits);
		logic [BCD_W-1:0] b;
		b = bcd_in;
		for (int k = 0; k < BITS_PER_STAGE; k++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[4*d +: 4] >= 4'd5) begin
					b[4*d +: 4] = b[4*d +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], bits[BITS_PER_STAGE-1-k]};
		end
		return b;
	endfunction

endpackage

/* hdl/sitda_if.sv */
// Valid/ready channel interfaces for the integer input and the character output.
interface sitda_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface sitda_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

/* hdl/sitda_dabble_stage.sv */
// One pipeline stage of the binary to BCD conversion, eight bits per stage.
module sitda_dabble_stage
	import sitda_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stage_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output stage_t out_data
);

	logic   valid_q;
	stage_t data_q;
	stage_t next_data;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		next_data.neg = in_data.neg;
		next_data.mag = {in_data.mag[VALUE_W-BITS_PER_STAGE-1:0], {BITS_PER_STAGE{1'b0}}};
		next_data.bcd = dabble8(in_data.bcd, in_data.mag[VALUE_W-1 -: BITS_PER_STAGE]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

endmodule

/* hdl/sitda_serializer.sv */
// Output register that emits the sign and the significant digits one character at a time.
module sitda_serializer
	import sitda_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stage_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output logic [7:0] out_char,
	output logic   out_last
);

	logic       valid_q;
	logic       more_q;
	logic [3:0] pos_q;
	logic [7:0] char_q;
	logic       last_q;
	logic [3:0] digits_q [NUM_DIGITS];
	logic [3:0] num_dig;
	logic       take;
	logic       load;
	logic       advance;

	// Number of significant digits, at least one so that zero prints as '0'.
	always_comb begin
		num_dig = 4'd1;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (in_data.bcd[4*d +: 4] != 4'd0) begin
				num_dig = 4'(d + 1);
			end
		end
	end

	assign take      = valid_q && out_ready;
	assign in_ready  = !valid_q || (take && !more_q);
	assign load      = in_ready && in_valid;
	assign advance   = take && more_q;
	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			more_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			more_q  <= in_data.neg || (num_dig > 4'd1);
		end else if (advance) begin
			valid_q <= 1'b1;
			more_q  <= (pos_q != 4'd0);
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				digits_q[d] <= in_data.bcd[4*d +: 4];
			end
			if (in_data.neg) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
				pos_q  <= num_dig - 4'd1;
			end else begin
				char_q <= CHAR_ZERO | {4'd0, in_data.bcd[4*(num_dig-4'd1) +: 4]};
				last_q <= (num_dig == 4'd1);
				pos_q  <= num_dig - 4'd2;
			end
		end else if (advance) begin
			char_q <= CHAR_ZERO | {4'd0, digits_q[pos_q]};
			last_q <= (pos_q == 4'd0);
			pos_q  <= pos_q - 4'd1;
		end
	end

endmodule

/* hdl/signed_int_to_decimal_ascii_unit.sv */
// The first character of a value is offered once the value has passed the conversion pipeline into the serializer.
// Each value then yields one to eleven characters, one per cycle while the sink is ready.
// The output serializer takes a new value only as the last character of the previous one is taken;
// the five-stage conversion pipeline ahead of it takes a new value each cycle until it fills up.
// Reset (arst_n low) clears every valid bit at once; payload registers are not reset.
// Top level of the signed 32-bit integer to decimal text unit.
module signed_int_to_decimal_ascii_unit
	import sitda_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	sitda_in_if.sink    ints,
	sitda_out_if.source chars
);

	// The first stage takes the magnitude. Negation is done modulo 2^32, so the
	// most negative value becomes 2^31 and converts like any other.
	logic   valid_s1;
	stage_t data_s1;
	logic   ready_s1;

	// Valid, ready and data between successive pipeline stages.
	logic   stg_valid [DABBLE_STAGES+1];
	logic   stg_ready [DABBLE_STAGES+1];
	stage_t stg_data  [DABBLE_STAGES+1];

	assign ints.ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ints.ready) begin
			valid_s1 <= ints.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ints.ready && ints.valid) begin
			data_s1.neg <= ints.value[VALUE_W-1];
			data_s1.mag <= ints.value[VALUE_W-1] ? (~ints.value + 32'd1) : ints.value;
			data_s1.bcd <= '0;
		end
	end

	assign stg_valid[0] = valid_s1;
	assign stg_data[0]  = data_s1;
	assign ready_s1     = stg_ready[0];

	// Double-dabble conversion, eight magnitude bits per stage.
	for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
		sitda_dabble_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[g]),
			.in_ready  (stg_ready[g]),
			.in_data   (stg_data[g]),
			.out_valid (stg_valid[g+1]),
			.out_ready (stg_ready[g+1]),
			.out_data  (stg_data[g+1])
		);
	end

	// The serializer strips leading zeros and puts the sign ahead of the digits.
	sitda_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[DABBLE_STAGES]),
		.in_ready  (stg_ready[DABBLE_STAGES]),
		.in_data   (stg_data[DABBLE_STAGES]),
		.out_valid (chars.valid),
		.out_ready (chars.ready),
		.out_char  (chars.char_code),
		.out_last  (chars.last_char)
	);

`ifndef ASSERT_OFF
	// A character that is not the last of its text is followed at once by the next one.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready && !chars.last_char |=> chars.valid)
		else $error("character run broken before its last character");

	// The sign is always followed by at least one digit.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready && (chars.char_code == CHAR_MINUS)
		|=> chars.valid && (chars.char_code != CHAR_MINUS))
		else $error("sign not followed by a digit");

	// Every other character offered is a decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && (chars.char_code != CHAR_MINUS)
		|-> (chars.char_code >= CHAR_ZERO) && (chars.char_code <= CHAR_NINE))
		else $error("character is neither a sign nor a digit");
`endif

endmodule

/* dv/decimal_text_checker.sv */
// Checker that predicts the decimal text of each accepted integer and compares every character.
`timescale 1ns / 100ps

module decimal_text_checker
	import sitda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       int_valid,
	input  logic       int_ready,
	input  logic [31:0] int_value,
	input  logic       char_valid,
	input  logic       char_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output int         pending,
	output int         fail_count,
	output int         char_count
);

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	text_char_t expected_text[$];
	text_char_t want;

	// Appends the characters of one value, sign first, then digits most significant first.
	function automatic void predict_text(input logic [31:0] value);
		logic [31:0] mag;
		logic [31:0] rem;
		logic [7:0]  digits[$];
		text_char_t  c;
		mag = value[31] ? (~value + 32'd1) : value;
		do begin
			rem = mag % 32'd10;
			digits.push_front(CHAR_ZERO + rem[7:0]);
			mag = mag / 32'd10;
		end while (mag != 32'd0);
		if (value[31]) begin
			c.code = CHAR_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		foreach (digits[i]) begin
			c.code = digits[i];
			c.last = (i == digits.size() - 1);
			expected_text.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			expected_text.delete();
			fail_count = 0;
			char_count = 0;
			pending <= 0;
		end else begin
			if (int_valid && int_ready) begin
				predict_text(int_value);
			end
			if (char_valid && char_ready) begin
				char_count = char_count + 1;
				if (expected_text.size() == 0) begin
					$error("unexpected character transaction: char_code 0x%02h last_char %0b",
						char_code, last_char);
					fail_count = fail_count + 1;
				end else begin
					want = expected_text.pop_front();
					if (char_code !== want.code) begin
						$error("char_code mismatch: expected 0x%02h, actual 0x%02h",
							want.code, char_code);
						fail_count = fail_count + 1;
					end
					if (last_char !== want.last) begin
						$error("last_char mismatch: expected %0b, actual %0b",
							want.last, last_char);
						fail_count = fail_count + 1;
					end
				end
			end
			pending <= expected_text.size();
		end
	end

endmodule

/* dv/signed_int_to_decimal_ascii_unit_tb.sv */
// Top-level testbench for the signed integer to decimal text unit: stimulus, flow control, verdict.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_unit_tb;

	import sitda_pkg::*;

	localparam int RANDOM_PER_PHASE = 65;
	localparam int NUM_PHASES       = 4;
	localparam int TAIL_CYCLES      = 20;

	logic clk = 1'b0;
	logic arst_n;

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int send_idle_pct;
	int recv_stall_pct;
	int values_sent;

	int pending;
	int fail_count;
	int char_count;

	// Idling mix per phase: none, sender only, receiver only, then both sides.
	int send_mix[NUM_PHASES] = '{0, 51, 0, 36};
	int recv_mix[NUM_PHASES] = '{0, 0, 51, 36};

	// Corner values: zero, one digit each side, the digit-count boundaries at 10, 100 and 1e9,
	// both extremes of the range and the value next to the most negative one.
	int corner_values[20] = '{
		0, 1, -1, 5, 9, -9, 10, -10, 99, 100, -100,
		999999999, 1000000000, -1000000000, 123456789, -987654321,
		2147483647, -2147483647, 32'h8000_0000, -2147483640
	};

	sitda_in_if  in_if ();
	sitda_out_if out_if ();

	signed_int_to_decimal_ascii_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.ints   (in_if),
		.chars  (out_if)
	);

	// The checker only watches both channels; it never drives them.
	decimal_text_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.int_valid  (in_if.valid),
		.int_ready  (in_if.ready),
		.int_value  (in_if.value),
		.char_valid (out_if.valid),
		.char_ready (out_if.ready),
		.char_code  (out_if.char_code),
		.last_char  (out_if.last_char),
		.pending    (pending),
		.fail_count (fail_count),
		.char_count (char_count)
	);

	// 20 ns clock, low half first.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver flow control: ready is redrawn every cycle from the current stall rate,
	// so stalls can land on any character position of a value's text.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offers one value and returns at the edge where its transaction is accepted.
	// Valid is left high so that a following value can go out back to back; the next
	// call or the drain task decides whether it drops.
	task automatic send_value(input logic [31:0] v);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.value <= v;
		@(posedge clk);
		while (!in_if.ready) begin
			@(posedge clk);
		end
		values_sent = values_sent + 1;
	endtask

	// Holds the sender off until every predicted character has been seen.
	task automatic drain_text();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Most draws pick a digit count first, so short and long texts are equally common;
	// the rest are raw 32-bit patterns or one of zero, both extremes and minus one.
	function automatic logic [31:0] random_value();
		int unsigned    pick;
		int unsigned    ndig;
		logic           neg;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned cap;
		logic [31:0]    mag;
		pick = $urandom_range(9);
		if (pick < 3) begin
			return $urandom();
		end
		if (pick == 9) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h8000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		ndig = $urandom_range(10, 1);
		neg  = 1'($urandom_range(1));
		lo   = 1;
		repeat (ndig - 1) begin
			lo = lo * 10;
		end
		hi  = lo * 10 - 1;
		cap = neg ? 64'd2147483648 : 64'd2147483647;
		if (hi > cap) begin
			hi = cap;
		end
		if (ndig == 1) begin
			lo = 0;
		end
		mag = $urandom_range(hi[31:0], lo[31:0]);
		return neg ? (~mag + 32'd1) : mag;
	endfunction

	initial begin
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		values_sent    = 0;
		in_if.valid    <= 1'b0;
		in_if.value    <= '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners with both sides running flat out.
		foreach (corner_values[i]) begin
			send_value(corner_values[i]);
		end
		drain_text();

		// Random values under each idling mix. Every phase starts from an empty pipeline,
		// and in the last one the sender also waits mid-phase for all text to come out.
		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle_pct  = send_mix[p];
			recv_stall_pct <= recv_mix[p];
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (p == NUM_PHASES - 1 && n == RANDOM_PER_PHASE / 2) begin
					drain_text();
				end
				send_value(random_value());
			end
			drain_text();
		end

		// Let any stray character show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Summary: %0d values, corners plus random texts of 1 to 10 digits,",
			values_sent);
		$display("Summary: %0d characters under no idling, sender gaps, receiver stalls and both.",
			char_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
